[sv/pcbs_pkg.sv]
// Shared constants for the pressure control breath sequencer.
// No dependencies; imported by the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pcbs_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned CntW   = 5;   // holds DataW itself
  localparam int unsigned SliceMs = 10;

  localparam logic [1:0] ModeStop  = 2'd0;
  localparam logic [1:0] ModePos   = 2'd1;
  localparam logic [1:0] ModePress = 2'd2;
  localparam logic [1:0] ModeSpeed = 2'd3;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrVolHigh = 2'd1;
  localparam logic [1:0] ErrVolLow  = 2'd2;
  localparam logic [1:0] ErrPhase   = 2'd3;

  localparam logic [2:0] PhOpen  = 3'd0;
  localparam logic [2:0] PhWait  = 3'd1;
  localparam logic [2:0] PhStart = 3'd2;
  localparam logic [2:0] PhRamp  = 3'd3;
  localparam logic [2:0] PhHold  = 3'd4;
  localparam logic [2:0] PhExh   = 3'd5;

  localparam logic [2:0] RegPeak   = 3'd0;
  localparam logic [2:0] RegRamp   = 3'd1;
  localparam logic [2:0] RegInsp   = 3'd2;
  localparam logic [2:0] RegExp    = 3'd3;
  localparam logic [2:0] RegVolLim = 3'd4;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
  } div_stat_t;

endpackage

`default_nettype wire

[sv/pcbs_div.sv]
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on pcbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcbs_div import pcbs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DataW-1:0] dividend_i,
  input  wire logic [DataW-1:0] divisor_i,
  output div_stat_t             stat_o
);

  logic [DataW-1:0] a_q, a_d;
  logic [DataW-1:0] r_q, r_d;
  logic [DataW-1:0] d_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DataW:0]   trial;
  logic             ge;

  assign trial = {r_q, a_q[DataW-1]};
  assign ge    = trial >= {1'b0, d_q};

  always_comb begin
    a_d    = a_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = dividend_i;
      r_d    = '0;
      cnt_d  = CntW'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      r_d   = ge ? DataW'(trial - {1'b0, d_q}) : trial[DataW-1:0];
      a_d   = {a_q[DataW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    r_q <= r_d;
    if (start_i) begin
      d_q <= divisor_i;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = a_q;

endmodule

`default_nettype wire

[sv/pressure_control_breath_sequencer.sv]
// Top level of the pressure control breath sequencer: phase sequencer,
// timers, output register. Depends on pcbs_pkg and pcbs_div.
//
//   channel   dir  payload (low bit up)
//   s_axis    in   tdata: motor_stopped[0], measured_volume[16:1], zero[23:17]
//   m_axis    out  tdata: drive_mode_out[1:0], pressure_target[17:2],
//                         error_code[19:18], zero[23:20]
//   cfg       in   cfg_we_i / cfg_addr_i / cfg_wdata_i, write only
//
// A ramp tick short of ramp_time holds the input through the decode state, the
// divider on peak/ramp_time (the multiply is registered as the quotient is
// done), the saturate state and the emit state, which waits while the output
// register is full and not taken. Every other tick passes decode and emit only.
// tready is high only in the idle state. The result sits in an output register,
// so the next tick is taken while it waits. Reset: open phase, drive mode stop.
`timescale 1ns / 1ps
`default_nettype none

module pressure_control_breath_sequencer import pcbs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [23:0]      s_axis_tdata,   // motor_stopped, measured_volume
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // drive_mode_out, pressure_target,
                                                // error_code
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_addr_i,
  input  wire logic [DataW-1:0] cfg_wdata_i
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SCalc = 3'd1;
  localparam logic [2:0] SDiv  = 3'd2;
  localparam logic [2:0] SSat  = 3'd3;
  localparam logic [2:0] SEmit = 3'd4;

  function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] t);
    logic [DataW:0] s;
    s = {1'b0, t} + (DataW+1)'(SliceMs);
    return s[DataW] ? '1 : s[DataW-1:0];
  endfunction

  // configuration
  logic [DataW-1:0] peak_q, ramp_q, insp_lim_q, exp_lim_q, vol_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q     <= DataW'(0);
      ramp_q     <= DataW'(1000);
      insp_lim_q <= DataW'(2000);
      exp_lim_q  <= DataW'(3000);
      vol_lim_q  <= DataW'(65535);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegPeak:   peak_q     <= cfg_wdata_i;
        RegRamp:   ramp_q     <= cfg_wdata_i;
        RegInsp:   insp_lim_q <= cfg_wdata_i;
        RegExp:    exp_lim_q  <= cfg_wdata_i;
        RegVolLim: vol_lim_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer and breath state
  logic [2:0]       st_q, st_d;
  logic [2:0]       phase_q, phase_d;
  logic [DataW-1:0] insp_q, insp_d;
  logic [DataW-1:0] exp_q, exp_d;
  logic [1:0]       mode_q, mode_d;
  logic [DataW-1:0] sp_q, sp_d;
  logic [1:0]       err_q, err_d;
  logic             stop_q;
  logic [DataW-1:0] vol_q;
  logic [2*DataW-1:0] prod_q;
  logic             out_vld_q, out_vld_d;
  logic [23:0]      out_q;
  logic             div_start;
  div_stat_t        div_stat;

  logic             accept;
  logic             emit;
  logic [DataW-1:0] t_ins;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign emit   = (st_q == SEmit) && (!out_vld_q || m_axis_tready);
  assign t_ins  = sat_add(insp_q);

  pcbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (peak_q),
    .divisor_i  (ramp_q),
    .stat_o     (div_stat)
  );

  always_comb begin
    st_d      = st_q;
    phase_d   = phase_q;
    insp_d    = insp_q;
    exp_d     = exp_q;
    mode_d    = mode_q;
    sp_d      = sp_q;
    err_d     = err_q;
    div_start = 1'b0;
    unique case (st_q)
      SIdle: begin
        if (accept) begin
          st_d = SCalc;
        end
      end
      SCalc: begin
        err_d  = ErrNone;
        if (stop_q) begin
          mode_d = ModeStop;
        end
        st_d = SEmit;
        unique case (phase_q)
          PhOpen: begin
            mode_d  = ModePos;
            phase_d = PhWait;
          end
          PhWait: begin
            if (mode_d == ModeStop) begin
              phase_d = PhStart;
            end
          end
          PhStart: begin
            mode_d  = ModePress;
            sp_d    = '0;
            insp_d  = '0;
            phase_d = PhRamp;
          end
          PhRamp: begin
            insp_d = t_ins;
            if (t_ins >= ramp_q) begin
              sp_d    = peak_q;
              phase_d = PhHold;
            end else begin
              div_start = 1'b1;
              st_d      = SDiv;
            end
          end
          PhHold: begin
            insp_d = t_ins;
            priority if (t_ins > insp_lim_q) begin
              phase_d = PhExh;
            end else if (vol_q >= vol_lim_q) begin
              err_d   = ErrVolHigh;
              phase_d = PhExh;
            end else if (mode_d == ModeStop) begin
              err_d   = ErrVolLow;
              phase_d = PhExh;
            end
            if (phase_d == PhExh) begin
              exp_d  = '0;
              mode_d = ModeSpeed;
            end
          end
          PhExh: begin
            exp_d = sat_add(exp_q);
            if (exp_d > exp_lim_q) begin
              phase_d = PhOpen;
            end
          end
          default: begin
            err_d   = ErrPhase;
            mode_d  = ModeStop;
            phase_d = PhOpen;
          end
        endcase
      end
      SDiv: begin
        if (div_stat.done) begin
          st_d = SSat;
        end
      end
      SSat: begin
        sp_d = (prod_q[2*DataW-1:DataW] != '0) ? '1 : prod_q[DataW-1:0];
        st_d = SEmit;
      end
      SEmit: begin
        if (emit) begin
          st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (emit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SIdle;
      phase_q   <= PhOpen;
      insp_q    <= '0;
      exp_q     <= '0;
      mode_q    <= ModeStop;
      sp_q      <= '0;
      err_q     <= ErrNone;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      phase_q   <= phase_d;
      insp_q    <= insp_d;
      exp_q     <= exp_d;
      mode_q    <= mode_d;
      sp_q      <= sp_d;
      err_q     <= err_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stop_q <= s_axis_tdata[0];
      vol_q  <= s_axis_tdata[DataW:1];
    end
    // scale the ramp step by the elapsed time once the quotient is ready
    if (div_stat.done) begin
      prod_q <= div_stat.quot * insp_q;
    end
    if (emit) begin
      out_q <= {4'b0, err_q, sp_q, mode_q};
    end
  end

  assign s_axis_tready = (st_q == SIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
